// ----- rtl/indexed_sequence_store_core_macros.svh -----
// Assertion macros shared by the indexed sequence store RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef INDEXED_SEQUENCE_STORE_CORE_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_CORE_MACROS_SVH

// Check that a condition holds in the same cycle as its trigger.
`define ISS_ASSERT_NOW(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error(msg);

// Check that a condition holds in the cycle after its trigger.
`define ISS_ASSERT_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/iss_pkg.sv -----
// Shared types and constants for the indexed sequence store.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none

package iss_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int DATA_W   = 32;

    typedef enum logic [2:0] {
        FN_APPEND  = 3'd0,
        FN_PREPEND = 3'd1,
        FN_INSERT  = 3'd2,
        FN_REMOVE  = 3'd3,
        FN_GET     = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the request fields
        logic exec;   // carry out the held request and load the result
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/indexed_sequence_store_core.sv -----
// Top level of the indexed sequence store: stream ports, controller and datapath.
// Depends on iss_pkg, iss_ctrl, iss_datapath and indexed_sequence_store_core_macros.svh.
//
// Usage:
//   Requests arrive on the s_* stream: a function code (append, prepend, insert,
//   remove, get), a position and a signed 32-bit value. Every request gives
//   exactly one transaction on the m_* stream: a status (ok, position out of
//   range, store full), the value read by a successful get (zero otherwise) and
//   the count after the request. The store holds up to CAPACITY values (16).
//   A request is captured in the idle state and carried out in the execute state
//   once the result slot is free, when all cells shift at once and the result is
//   registered; no new request is taken until then.
//   Stall: while the receiver holds m_tready low a finished result waits in
//   the output register; one further request is still taken and held until
//   that result leaves, then s_tready stays low.
//   Reset: rst_n clears the count (empty store) and m_tvalid; the
//   cell contents are left as they are, since only positions below the count
//   are ever read.
`default_nettype none

`include "indexed_sequence_store_core_macros.svh"

module indexed_sequence_store_core
#(
    parameter int CAPACITY = iss_pkg::CAPACITY
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // func[2:0], position[7:3], value[39:8]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata    // status[1:0], read_value[33:2], count[38:34], 0
);

    iss_pkg::cmd_t                          cmd;
    iss_pkg::status_t                       res_status;
    logic signed [iss_pkg::DATA_W-1:0]      res_value;
    logic [iss_pkg::CNT_W-1:0]              res_count;

    // Sequence the request and result transactions.
    iss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    // Unpack the request fields straight into the datapath.
    iss_datapath
    #(
        .CAPACITY (CAPACITY)
    )
    u_datapath
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .func       (s_tdata[2:0]),
        .position   (s_tdata[7:3]),
        .value      (s_tdata[39:8]),
        .status     (res_status),
        .read_value (res_value),
        .count      (res_count)
    );

    // Pack the result, padding to whole bytes.
    assign m_tdata = {1'b0, res_count, res_value, res_status};

    // A taken request blocks the input for at least the execute cycle.
    `ISS_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
        "input accepted again directly after a request")
    // The count never passes the capacity.
    `ISS_ASSERT_NOW(a_count_bound, m_tvalid,
        res_count <= iss_pkg::CNT_W'(CAPACITY), "count beyond capacity")
    // A full status only comes from a store at capacity.
    `ISS_ASSERT_NOW(a_full_at_cap, m_tvalid && res_status == iss_pkg::ST_FULL,
        res_count == iss_pkg::CNT_W'(CAPACITY), "full status below capacity")
    // An out-of-range request reads nothing.
    `ISS_ASSERT_NOW(a_range_no_data, m_tvalid && res_status == iss_pkg::ST_RANGE,
        res_value == '0, "data returned with range error")

endmodule

`default_nettype wire

// ----- rtl/iss_ctrl.sv -----
// Controller for the indexed sequence store: request/result sequencing.
// Depends on iss_pkg.
`default_nettype none

module iss_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  wire logic          out_ready,
    output iss_pkg::cmd_t      cmd
);

    iss_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= iss_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        // drop the result once the receiver takes it
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            iss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = iss_pkg::S_EXEC;
                end
            end
            iss_pkg::S_EXEC:
            begin
                // hold until the result slot is free or freeing this cycle
                if (!out_valid_reg || out_ready)
                begin
                    cmd.exec       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = iss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = iss_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/iss_datapath.sv -----
// Datapath for the indexed sequence store: row of shifting cells, count, result.
// Depends on iss_pkg.
`default_nettype none

module iss_datapath
#(
    parameter int CAPACITY = iss_pkg::CAPACITY
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire iss_pkg::cmd_t                       cmd,
    input  wire logic [2:0]                          func,
    input  wire logic [iss_pkg::CNT_W-1:0]           position,
    input  wire logic signed [iss_pkg::DATA_W-1:0]   value,
    output iss_pkg::status_t                         status,
    output logic signed [iss_pkg::DATA_W-1:0]        read_value,
    output logic [iss_pkg::CNT_W-1:0]                count
);

    localparam int CAP   = CAPACITY;
    localparam int IDX_W = $clog2(CAP);
    localparam logic [iss_pkg::CNT_W-1:0] CAP_CNT = iss_pkg::CNT_W'(CAP);

    logic [2:0]                         func_reg;
    logic [iss_pkg::CNT_W-1:0]          pos_reg;
    logic signed [iss_pkg::DATA_W-1:0]  val_reg;
    logic signed [iss_pkg::DATA_W-1:0]  cells_reg [CAP];
    logic signed [iss_pkg::DATA_W-1:0]  cells_next [CAP];
    logic [iss_pkg::CNT_W-1:0]          count_reg, count_next;
    iss_pkg::status_t                   status_reg, status_next;
    logic signed [iss_pkg::DATA_W-1:0]  rd_reg, rd_next;

    logic                               full;
    logic                               do_ins;
    logic                               do_rem;
    logic [iss_pkg::CNT_W-1:0]          op_pos;

    assign full = (count_reg == CAP_CNT);

    // Decode the held request.
    always_comb
    begin
        status_next = iss_pkg::ST_OK;
        rd_next     = '0;
        do_ins      = 1'b0;
        do_rem      = 1'b0;
        op_pos      = pos_reg;
        count_next  = count_reg;
        case (iss_pkg::func_t'(func_reg))
            iss_pkg::FN_APPEND:
            begin
                op_pos = count_reg;
                if (full) status_next = iss_pkg::ST_FULL;
                else      do_ins      = 1'b1;
            end
            iss_pkg::FN_PREPEND:
            begin
                op_pos = '0;
                if (full) status_next = iss_pkg::ST_FULL;
                else      do_ins      = 1'b1;
            end
            iss_pkg::FN_INSERT:
            begin
                if (pos_reg > count_reg) status_next = iss_pkg::ST_RANGE;
                else if (full)           status_next = iss_pkg::ST_FULL;
                else                     do_ins      = 1'b1;
            end
            iss_pkg::FN_REMOVE:
            begin
                if (pos_reg >= count_reg) status_next = iss_pkg::ST_RANGE;
                else                      do_rem      = 1'b1;
            end
            iss_pkg::FN_GET:
            begin
                if (pos_reg >= count_reg) status_next = iss_pkg::ST_RANGE;
                else rd_next = cells_reg[pos_reg[IDX_W-1:0]];
            end
            default:
            begin
                status_next = iss_pkg::ST_OK;
            end
        endcase
        if (do_ins) count_next = count_reg + iss_pkg::CNT_W'(1);
        if (do_rem) count_next = count_reg - iss_pkg::CNT_W'(1);
    end

    // Each cell picks its own value, the new value, its left neighbour or its right neighbour.
    for (genvar gi = 0; gi < CAP; gi++)
    begin : g_cell
        logic signed [iss_pkg::DATA_W-1:0] left_val;
        logic signed [iss_pkg::DATA_W-1:0] right_val;
        logic [iss_pkg::CNT_W-1:0]         here;

        assign here = iss_pkg::CNT_W'(gi);

        if (gi == 0)
        begin : g_first
            assign left_val = val_reg;
        end
        else
        begin : g_mid_l
            assign left_val = cells_reg[gi-1];
        end

        if (gi == CAP-1)
        begin : g_last
            assign right_val = cells_reg[gi];
        end
        else
        begin : g_mid_r
            assign right_val = cells_reg[gi+1];
        end

        always_comb
        begin
            cells_next[gi] = cells_reg[gi];
            if (do_ins)
            begin
                if (here == op_pos)     cells_next[gi] = val_reg;
                else if (here > op_pos) cells_next[gi] = left_val;
            end
            else if (do_rem)
            begin
                if (here >= op_pos)     cells_next[gi] = right_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            pos_reg  <= position;
            val_reg  <= value;
        end
        if (cmd.exec)
        begin
            cells_reg  <= cells_next;
            status_reg <= status_next;
            rd_reg     <= rd_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.exec)
        begin
            count_reg <= count_next;
        end
    end

    assign status     = status_reg;
    assign read_value = rd_reg;
    assign count      = count_reg;

endmodule

`default_nettype wire

// ----- test/indexed_sequence_store_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for indexed_sequence_store_core: stream requests in, results checked.
// Depends on iss_pkg and the indexed_sequence_store_core RTL; needs no files or arguments.

module indexed_sequence_store_core_tb;

    localparam int          RANDOM_ITEMS   = 1800;
    localparam int          CALM_TAIL      = 300;   // final requests run with no idling
    localparam int          PHASE_LEN      = 60;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_CYCLES   = 8;
    localparam int          REPORT_LIMIT   = 10;
    localparam logic [2:0]  FN_CODE_MAX    = 3'd7;
    localparam logic [31:0] VAL_MAX        = 32'h7FFF_FFFF;
    localparam logic [31:0] VAL_MIN        = 32'h8000_0000;
    localparam logic [31:0] VAL_ONES       = 32'hFFFF_FFFF;

    // Result fields, lowest bits last so the layout matches m_tdata[38:0].
    typedef struct packed {
        logic [4:0]                 count;
        logic [iss_pkg::DATA_W-1:0] read_value;
        iss_pkg::status_t           status;
    } store_reply_t;

    // Shadow copy of the sequence plus the replies still owed by the block.
    class store_scoreboard;
        logic [iss_pkg::DATA_W-1:0] shadow_seq[$];
        store_reply_t               awaited_replies[$];
        int                         errors;
        int                         checked;
        int                         range_seen;
        int                         full_seen;
        int                         peak_level;

        function int level();
            return shadow_seq.size();
        endfunction

        function int pending();
            return awaited_replies.size();
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
        endfunction

        // Apply one accepted request to the shadow sequence and queue its reply.
        function void note_request(logic [2:0] fn, logic [4:0] pos,
                                   logic [iss_pkg::DATA_W-1:0] val);
            store_reply_t reply;
            int           lvl;
            lvl              = shadow_seq.size();
            reply.status     = iss_pkg::ST_OK;
            reply.read_value = '0;
            case (fn)
                iss_pkg::FN_APPEND:
                    if (lvl >= iss_pkg::CAPACITY) reply.status = iss_pkg::ST_FULL;
                    else shadow_seq.push_back(val);
                iss_pkg::FN_PREPEND:
                    if (lvl >= iss_pkg::CAPACITY) reply.status = iss_pkg::ST_FULL;
                    else shadow_seq.push_front(val);
                iss_pkg::FN_INSERT:
                    // range is judged before fullness
                    if (pos > lvl) reply.status = iss_pkg::ST_RANGE;
                    else if (lvl >= iss_pkg::CAPACITY) reply.status = iss_pkg::ST_FULL;
                    else shadow_seq.insert(pos, val);
                iss_pkg::FN_REMOVE:
                    if (pos >= lvl) reply.status = iss_pkg::ST_RANGE;
                    else shadow_seq.delete(pos);
                iss_pkg::FN_GET:
                    if (pos >= lvl) reply.status = iss_pkg::ST_RANGE;
                    else reply.read_value = shadow_seq[pos];
                default: ;  // unknown codes leave the store alone
            endcase
            reply.count = 5'(shadow_seq.size());
            if (reply.status == iss_pkg::ST_RANGE) range_seen++;
            if (reply.status == iss_pkg::ST_FULL) full_seen++;
            if (shadow_seq.size() > peak_level) peak_level = shadow_seq.size();
            awaited_replies.push_back(reply);
        endfunction

        function void check_result(logic [39:0] word);
            store_reply_t got;
            store_reply_t want;
            got = store_reply_t'(word[38:0]);
            if (awaited_replies.size() == 0)
            begin
                flag($sformatf("unexpected result status %0d read %h count %0d",
                               got.status, got.read_value, got.count));
                return;
            end
            want = awaited_replies.pop_front();
            checked++;
            if (got.status !== want.status || got.read_value !== want.read_value
                || got.count !== want.count)
                flag($sformatf({"expected status %0d read %h count %0d, ",
                                "got status %0d read %h count %0d"},
                               want.status, want.read_value, want.count,
                               got.status, got.read_value, got.count));
        endfunction

        function void finish_check();
            while (awaited_replies.size() != 0)
            begin
                store_reply_t left;
                left = awaited_replies.pop_front();
                flag($sformatf("result never arrived: status %0d read %h count %0d",
                               left.status, left.read_value, left.count));
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // func[2:0], position[7:3], value[39:8]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;         // status[1:0], read_value[33:2], count[38:34], 0

    store_scoreboard sb;
    int              send_gap_pct = 0;
    int              stall_pct    = 0;
    int              stall_left   = 0;
    int              quiet_cycles = 0;

    indexed_sequence_store_core uut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 0;
    end

    // Receiver: at random, hold m_tready low in bursts of random length.
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (rst_n && stall_pct > 0 && $urandom_range(99) < stall_pct)
        begin
            stall_left = $urandom_range(1, 9) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= rst_n;
    end

    // Observe both streams at each edge; drop out if nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata[2:0], s_tdata[7:3], s_tdata[39:8]);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // Present one request and hold it until the transaction completes.
    task automatic send_request(input logic [2:0] fn, input logic [4:0] pos,
                                input logic [31:0] val);
        int gap;
        if (send_gap_pct > 0 && $urandom_range(99) < send_gap_pct)
        begin
            gap = $urandom_range(1, 9);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {val, pos, fn};
        do @(posedge clk); while (!s_tready);
    endtask

    // Mostly well-formed requests at the current fill level; some stray positions and unknown codes.
    task automatic send_random(input int grow_pct);
        logic [2:0]  fn;
        logic [4:0]  pos;
        logic [31:0] val;
        int          lvl;
        int          pick;
        lvl  = sb.level();
        pick = $urandom_range(99);
        if (pick < 4)
            fn = 3'($urandom_range(FN_CODE_MAX, iss_pkg::FN_GET + 1));
        else if (pick < 30)
            fn = iss_pkg::FN_GET;
        else if ($urandom_range(99) < grow_pct)
        begin
            case ($urandom_range(2))
                0:       fn = iss_pkg::FN_APPEND;
                1:       fn = iss_pkg::FN_PREPEND;
                default: fn = iss_pkg::FN_INSERT;
            endcase
        end
        else
            fn = iss_pkg::FN_REMOVE;

        if ($urandom_range(9) == 0 || fn == iss_pkg::FN_APPEND || fn == iss_pkg::FN_PREPEND)
            pos = 5'($urandom_range(31));
        else if (fn == iss_pkg::FN_INSERT)
            pos = 5'($urandom_range(lvl));
        else
            pos = (lvl > 0) ? 5'($urandom_range(lvl - 1)) : 5'd0;

        case ($urandom_range(15))
            0:       val = VAL_MAX;
            1:       val = VAL_MIN;
            2:       val = VAL_ONES;
            3:       val = '0;
            default: val = $urandom();
        endcase
        send_request(fn, pos, val);
    endtask

    initial
    begin
        int grow_pct;
        int n;
        int k;
        sb = new();
        grow_pct = 50;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: empty store, unknown code, extremes, both ends, then fill past capacity.
        send_request(iss_pkg::FN_GET,     5'd0,  32'h0);
        send_request(iss_pkg::FN_REMOVE,  5'd0,  32'h0);
        send_request(iss_pkg::FN_INSERT,  5'd1,  VAL_ONES);
        send_request(FN_CODE_MAX,         5'd31, VAL_ONES);
        send_request(3'(iss_pkg::FN_GET + 1), 5'd0, 32'h0);
        send_request(iss_pkg::FN_APPEND,  5'd0,  VAL_MAX);
        send_request(iss_pkg::FN_PREPEND, 5'd31, VAL_MIN);
        send_request(iss_pkg::FN_INSERT,  5'd1,  VAL_ONES);
        send_request(iss_pkg::FN_INSERT,  5'd3,  32'h0);
        send_request(iss_pkg::FN_GET,     5'd3,  32'h0);
        send_request(iss_pkg::FN_GET,     5'd31, 32'h0);
        send_request(iss_pkg::FN_REMOVE,  5'd1,  32'h0);
        for (k = 0; k < 13; k++)
            send_request(iss_pkg::FN_APPEND, 5'd0, $urandom());
        send_request(iss_pkg::FN_APPEND,  5'd0,  32'h1);
        send_request(iss_pkg::FN_INSERT,  5'd16, 32'h1);
        send_request(iss_pkg::FN_INSERT,  5'd17, 32'h1);
        send_request(iss_pkg::FN_PREPEND, 5'd0,  32'h1);

        // Random: each phase picks a growth or shrinkage bias and an idle mix at random.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % PHASE_LEN == 0)
            begin
                case ($urandom_range(2))
                    0:       grow_pct = 80;
                    1:       grow_pct = 50;
                    default: grow_pct = 20;
                endcase
                case ($urandom_range(2))
                    0:       send_gap_pct = 0;
                    1:       send_gap_pct = 15;
                    default: send_gap_pct = 40;
                endcase
                case ($urandom_range(2))
                    0:       stall_pct = 0;
                    1:       stall_pct = 15;
                    default: stall_pct = 40;
                endcase
            end
            if (n >= RANDOM_ITEMS - CALM_TAIL)
            begin
                send_gap_pct = 0;
                stall_pct    = 0;
            end
            send_random(grow_pct);
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        sb.finish_check();

        $display("Covered %0d checked results: %0d out-of-range and %0d full rejections,",
                 sb.checked, sb.range_seen, sb.full_seen);
        $display("peak fill %0d of %0d, with sender gaps and receiver stalls.",
                 sb.peak_level, iss_pkg::CAPACITY);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/iss_pkg.sv
rtl/iss_ctrl.sv
rtl/iss_datapath.sv
rtl/indexed_sequence_store_core.sv
test/indexed_sequence_store_core_tb.sv
